@@ hdl/banked_rom_sram_mapper_macros.svh @@
// Assertion macros shared by the mapper RTL.
`ifndef BANKED_ROM_SRAM_MAPPER_MACROS_SVH
`define BANKED_ROM_SRAM_MAPPER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BRSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BRSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/brsm_pkg.sv @@
// Constants, codes and helper functions of the banked ROM and SRAM mapper.
`timescale 1ns / 1ps

package brsm_pkg;

  localparam int unsigned ROM_BYTES   = 524288;
  localparam int unsigned PAGE_BYTES  = 16384;
  localparam int unsigned SRAM_BYTES  = 32768;
  localparam int unsigned SRAM_WINDOW = 16384;

  localparam int unsigned ROM_AW  = $clog2(ROM_BYTES);
  localparam int unsigned PAGE_AW = $clog2(PAGE_BYTES);
  localparam int unsigned SRAM_AW = $clog2(SRAM_BYTES);
  localparam int unsigned LEN_W   = 20;
  localparam int unsigned BANK_W  = ROM_AW - PAGE_AW;
  localparam int unsigned BC_W    = $clog2(ROM_BYTES / PAGE_BYTES + 1);

  localparam logic [15:0] ADDR_LOW_ROM   = 16'h0400;
  localparam logic [15:0] ADDR_SRAM_LO   = 16'h8000;
  localparam logic [15:0] ADDR_UNMAPPED  = 16'hC000;
  localparam logic [15:0] ADDR_CONTROL   = 16'hFFFC;
  localparam logic [15:0] ADDR_BANK_BASE = 16'hFFFD;

  localparam int unsigned CTRL_SRAM_ON   = 3;
  localparam int unsigned CTRL_SRAM_HIGH = 2;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

  typedef enum logic [2:0] {
    MODE_READ    = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_LOAD    = 3'd2,
    MODE_CLEAN   = 3'd3,
    MODE_RESTART = 3'd4
  } mode_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(ROM_BYTES)) begin
      return LEN_W'(ROM_BYTES);
    end
    return len;
  endfunction

  function automatic logic [BC_W-1:0] bank_count_of(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] eff;
    logic [LEN_W:0]   sum;
    eff = clamp_len(len);
    sum = {1'b0, eff} + (LEN_W + 1)'(PAGE_BYTES - 1);
    if (eff == '0) begin
      return BC_W'(1);
    end
    return BC_W'(sum >> PAGE_AW);
  endfunction

  // Restart value of bank register idx (0..2), which is idx modulo the bank count.
  function automatic logic [7:0] restart_bank(input logic [1:0] idx,
                                              input logic [BC_W-1:0] count);
    if (BC_W'(idx) < count) begin
      return 8'(idx);
    end
    return 8'd0;
  endfunction

endpackage

@@ hdl/banked_rom_sram_mapper.sv @@
// Cartridge mapper with banked ROM, battery SRAM and mapper registers.
//
// One item is in flight at a time and each gives one result. Control, clean,
// restart and ROM load items and accesses that read no memory go from decode
// straight to the result. SRAM reads and SRAM writes (a read, compare and,
// if the byte differs, write back of one entry) pass through a memory wait.
// Reads of the first 1 KB skip the remainder unit when the ROM is 1 KB or
// longer. Reads of ROM short of 1 KB and banked ROM reads pass through the
// bit-serial remainder unit, which reduces the address or the page number
// modulo the ROM length or the bank count in ten steps. A banked read past
// the ROM end skips the memory. A result still waiting in the output register
// holds the item back for as long as it waits. After reset and after every
// rom_length write the 32768 SRAM bytes are zeroed one byte per cycle in a
// pass during which no item is accepted. A rom_length write is taken at any
// time and keeps in_ready low in its cycle. It discards an item in flight, so
// it belongs between items.
`timescale 1ns / 1ps
`include "banked_rom_sram_mapper_macros.svh"

module banked_rom_sram_mapper import brsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  rom_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [15:0]       bus_address,
  input  logic [7:0]        write_byte,
  input  logic [ROM_AW-1:0] rom_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_byte,
  output logic              save_dirty,
  output logic              control_hit,
  output logic              sram_hit
);

  localparam int unsigned MOD_W  = 10;
  localparam int unsigned MOD_CW = $clog2(MOD_W);
  localparam logic [SRAM_AW-1:0] CLR_LAST = SRAM_AW'(SRAM_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_ROM_ADDR,
    S_MEM_WAIT,
    S_DONE
  } state_t;

  state_t state;

  logic [LEN_W-1:0]   rom_len;
  logic [7:0]         page_bank [3];
  logic [7:0]         ctrl;
  logic               dirty;
  logic [SRAM_AW-1:0] clr_cnt;

  logic [2:0]         mode_q;
  logic [15:0]        addr_q;
  logic [7:0]         data_q;
  logic [ROM_AW-1:0]  pos_q;

  logic [7:0]         res_byte;
  logic               res_chit;
  logic               res_shit;

  logic [MOD_W-1:0]   mod_dvd;
  logic [MOD_W-1:0]   mod_div;
  logic [MOD_W-1:0]   mod_rem;
  logic [MOD_CW-1:0]  mod_cnt;
  logic               mod_page;

  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] sram_mem [SRAM_BYTES];
  logic [7:0] rom_rdata;
  logic [7:0] sram_rdata;

  logic               cfg_fire;
  logic               in_fire;
  logic [LEN_W-1:0]   eff_len;
  logic [BC_W-1:0]    bank_cnt;
  logic               in_window;
  logic               sram_on;
  logic               ctrl_hit;
  logic [15:0]        sram_pos;
  logic               sram_ok;
  logic [SRAM_AW-1:0] sram_raddr;
  logic               sram_we;
  logic [SRAM_AW-1:0] sram_waddr;
  logic [7:0]         sram_wdata;
  logic               rom_we;
  logic [LEN_W-1:0]   rom_off;
  logic [ROM_AW-1:0]  rom_raddr;
  logic [1:0]         page_sel;
  logic [1:0]         bank_widx;
  logic [MOD_W:0]     mod_trial;
  logic [MOD_W-1:0]   mod_rem_next;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid & in_ready;

  assign eff_len   = clamp_len(rom_len);
  assign bank_cnt  = bank_count_of(rom_len);
  assign in_window = (addr_q >= ADDR_SRAM_LO) && (addr_q < ADDR_UNMAPPED);
  assign sram_on   = ctrl[CTRL_SRAM_ON];
  assign ctrl_hit  = (addr_q >= ADDR_CONTROL);
  assign sram_pos  = {1'b0, ctrl[CTRL_SRAM_HIGH], addr_q[PAGE_AW-1:0]};
  assign sram_ok   = (sram_pos < 16'(SRAM_BYTES));
  assign sram_raddr = sram_pos[SRAM_AW-1:0];
  assign page_sel  = (addr_q[15:PAGE_AW] < 2'd3) ? addr_q[15:PAGE_AW] : 2'd0;
  assign bank_widx = 2'(addr_q - ADDR_BANK_BASE);

  always_comb begin
    mod_trial = {mod_rem, mod_dvd[MOD_W-1]};
    if (mod_trial >= {1'b0, mod_div}) begin
      mod_rem_next = MOD_W'(mod_trial - {1'b0, mod_div});
    end else begin
      mod_rem_next = mod_trial[MOD_W-1:0];
    end
  end

  always_comb begin
    if (mod_page) begin
      rom_off = LEN_W'({mod_rem[BANK_W-1:0], addr_q[PAGE_AW-1:0]});
    end else begin
      rom_off = LEN_W'(mod_rem);
    end
    rom_raddr = rom_off[ROM_AW-1:0];
    rom_we    = (state == S_DECODE) && (mode_q == MODE_LOAD) &&
                (LEN_W'(pos_q) < LEN_W'(ROM_BYTES));
    sram_we    = 1'b0;
    sram_waddr = sram_raddr;
    sram_wdata = data_q;
    if (state == S_CLEAR) begin
      sram_we    = 1'b1;
      sram_waddr = clr_cnt;
      sram_wdata = 8'd0;
    end else if ((state == S_MEM_WAIT) && (mode_q == MODE_WRITE) &&
                 (sram_rdata != data_q)) begin
      sram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[pos_q] <= data_q;
    end
    rom_rdata <= rom_mem[rom_raddr];
  end

  always_ff @(posedge clk) begin
    if (sram_we) begin
      sram_mem[sram_waddr] <= sram_wdata;
    end
    sram_rdata <= sram_mem[sram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rom_len   <= '0;
      ctrl      <= '0;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        page_bank[i] <= 8'd0;
      end
    end else begin
      if (out_valid && out_ready && (cfg_fire || (state != S_DONE))) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        rom_len <= rom_length;
        ctrl    <= '0;
        dirty   <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          page_bank[i] <= restart_bank(2'(i), bank_count_of(rom_length));
        end
        clr_cnt <= '0;
        state   <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == CLR_LAST) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_fire) begin
              mode_q <= mode;
              addr_q <= bus_address;
              data_q <= write_byte;
              pos_q  <= rom_position;
              state  <= S_DECODE;
            end
          end
          S_DECODE: begin
            res_byte <= OPEN_BUS;
            res_chit <= ((mode_q == MODE_READ) || (mode_q == MODE_WRITE)) && ctrl_hit;
            res_shit <= ((mode_q == MODE_READ) || (mode_q == MODE_WRITE)) && in_window &&
                        sram_on;
            case (mode_q)
              MODE_READ: begin
                if ((eff_len == '0) || (addr_q >= ADDR_UNMAPPED)) begin
                  state <= S_DONE;
                end else if (in_window && sram_on) begin
                  state <= sram_ok ? S_MEM_WAIT : S_DONE;
                end else if (addr_q < ADDR_LOW_ROM) begin
                  mod_page <= 1'b0;
                  if (eff_len[LEN_W-1:MOD_W] != '0) begin
                    mod_rem <= addr_q[MOD_W-1:0];
                    state   <= S_ROM_ADDR;
                  end else begin
                    mod_dvd <= addr_q[MOD_W-1:0];
                    mod_div <= eff_len[MOD_W-1:0];
                    mod_rem <= '0;
                    mod_cnt <= '0;
                    state   <= S_MOD;
                  end
                end else begin
                  mod_page <= 1'b1;
                  mod_dvd  <= MOD_W'(9'(page_bank[page_sel]) + 9'({ctrl[1:0], 3'b000}));
                  mod_div  <= MOD_W'(bank_cnt);
                  mod_rem  <= '0;
                  mod_cnt  <= '0;
                  state    <= S_MOD;
                end
              end
              MODE_WRITE: begin
                if (ctrl_hit) begin
                  if (addr_q == ADDR_CONTROL) begin
                    ctrl <= data_q;
                  end else begin
                    page_bank[bank_widx] <= data_q;
                  end
                  state <= S_DONE;
                end else if ((eff_len != '0) && in_window && sram_on && sram_ok) begin
                  state <= S_MEM_WAIT;
                end else begin
                  state <= S_DONE;
                end
              end
              MODE_CLEAN: begin
                dirty <= 1'b0;
                state <= S_DONE;
              end
              MODE_RESTART: begin
                ctrl  <= '0;
                dirty <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                  page_bank[i] <= restart_bank(2'(i), bank_cnt);
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
          S_MOD: begin
            mod_rem <= mod_rem_next;
            mod_dvd <= {mod_dvd[MOD_W-2:0], 1'b0};
            mod_cnt <= mod_cnt + 1'b1;
            if (mod_cnt == MOD_CW'(MOD_W - 1)) begin
              state <= S_ROM_ADDR;
            end
          end
          S_ROM_ADDR: begin
            if (rom_off < eff_len) begin
              state <= S_MEM_WAIT;
            end else begin
              state <= S_DONE;
            end
          end
          S_MEM_WAIT: begin
            if (mode_q == MODE_WRITE) begin
              if (sram_we) begin
                dirty <= 1'b1;
              end
            end else if (res_shit) begin
              res_byte <= sram_rdata;
            end else begin
              res_byte <= rom_rdata;
            end
            state <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid   <= 1'b1;
              read_byte   <= res_byte;
              save_dirty  <= dirty;
              control_hit <= res_chit;
              sram_hit    <= res_shit;
              state       <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  `BRSM_ASSERT_NEXT(a_one_item_at_a_time, in_fire, !in_ready, "New item taken while busy.")
  `BRSM_ASSERT_NEXT(a_sram_change_marks_dirty, sram_we && (state != S_CLEAR) && !cfg_fire, dirty, "SRAM change left dirty clear.")
  `BRSM_ASSERT_NOW(a_clear_pass_clean, state == S_CLEAR, !dirty, "Dirty set during SRAM clear.")
  `BRSM_ASSERT_NOW(a_bank_below_count, (state == S_ROM_ADDR) && mod_page, mod_rem < mod_div, "Bank remainder not reduced.")

endmodule

@@ tb/banked_rom_sram_mapper_tb.sv @@
// Self-checking testbench for the banked ROM and battery SRAM cartridge mapper.
`timescale 1ns / 1ps

module banked_rom_sram_mapper_tb import brsm_pkg::*; ();

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned BANK_STRIDE = 8;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       dirty;
    logic       reg_hit;
    logic       sram_win;
  } bus_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  rom_length = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        mode = MODE_READ;
  logic [15:0]       bus_address = '0;
  logic [7:0]        write_byte = '0;
  logic [ROM_AW-1:0] rom_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        read_byte;
  logic              save_dirty;
  logic              control_hit;
  logic              sram_hit;

  banked_rom_sram_mapper dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .rom_length   (rom_length),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .bus_address  (bus_address),
    .write_byte   (write_byte),
    .rom_position (rom_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .save_dirty   (save_dirty),
    .control_hit  (control_hit),
    .sram_hit     (sram_hit)
  );

  logic [7:0]  rom_image [int unsigned];
  logic [7:0]  sram_image [SRAM_BYTES];
  logic [7:0]  bank_image [3];
  logic [7:0]  control_image;
  logic        dirty_image;
  int unsigned cart_len;

  bus_result_t expected_bus_results [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned accept_stall_pct = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned bank_total();
    return (cart_len == 0) ? 1 : (cart_len + PAGE_BYTES - 1) / PAGE_BYTES;
  endfunction

  function automatic void restart_registers();
    for (int i = 0; i < 3; i++) begin
      bank_image[i] = 8'(i % bank_total());
    end
    control_image = '0;
    dirty_image = 1'b0;
  endfunction

  function automatic void cartridge_inserted(input logic [LEN_W-1:0] len);
    cart_len = (len > ROM_BYTES) ? ROM_BYTES : len;
    foreach (sram_image[i]) begin
      sram_image[i] = '0;
    end
    restart_registers();
  endfunction

  function automatic int unsigned sram_offset(input logic [15:0] a);
    return (control_image[CTRL_SRAM_HIGH] ? SRAM_WINDOW : 0) + (a - ADDR_SRAM_LO);
  endfunction

  // True when a bus read at this address returns a ROM byte; off is its position.
  function automatic bit rom_target(input logic [15:0] a, output int unsigned off);
    int unsigned bank;
    off = 0;
    if (cart_len == 0 || a >= ADDR_UNMAPPED) begin
      return 1'b0;
    end
    if (a >= ADDR_SRAM_LO && control_image[CTRL_SRAM_ON]) begin
      return 1'b0;
    end
    if (a < ADDR_LOW_ROM) begin
      off = a % cart_len;
      return 1'b1;
    end
    bank = (bank_image[a[15:14]] + control_image[1:0] * BANK_STRIDE) % bank_total();
    off = bank * PAGE_BYTES + a % PAGE_BYTES;
    return off < cart_len;
  endfunction

  function automatic bus_result_t mapper_step(input logic [2:0] op, input logic [15:0] a,
                                              input logic [7:0] v,
                                              input logic [ROM_AW-1:0] p);
    bus_result_t r;
    int unsigned off;
    r.rd_byte = OPEN_BUS;
    r.reg_hit = 1'b0;
    r.sram_win = 1'b0;
    if (op == MODE_READ || op == MODE_WRITE) begin
      r.reg_hit = a >= ADDR_CONTROL;
      r.sram_win = a >= ADDR_SRAM_LO && a < ADDR_UNMAPPED && control_image[CTRL_SRAM_ON];
    end
    case (op)
      MODE_READ: begin
        if (rom_target(a, off)) begin
          r.rd_byte = rom_image[off];
        end else if (r.sram_win && cart_len != 0 && sram_offset(a) < SRAM_BYTES) begin
          r.rd_byte = sram_image[sram_offset(a)];
        end
      end
      MODE_WRITE: begin
        if (a >= ADDR_CONTROL) begin
          if (a == ADDR_CONTROL) begin
            control_image = v;
          end else begin
            bank_image[a - ADDR_BANK_BASE] = v;
          end
        end else if (r.sram_win && cart_len != 0) begin
          off = sram_offset(a);
          if (off < SRAM_BYTES && sram_image[off] != v) begin
            sram_image[off] = v;
            dirty_image = 1'b1;
          end
        end
      end
      MODE_LOAD: rom_image[p] = v;
      MODE_CLEAN: dirty_image = 1'b0;
      MODE_RESTART: restart_registers();
      default: ;
    endcase
    r.dirty = dirty_image;
    return r;
  endfunction

  function automatic void set_traffic(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    accept_stall_pct = stall_pct;
  endfunction

  always @(posedge clk) begin : result_check
    bus_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bus_results.size() == 0) begin
        $error("Unexpected result item: read_byte %0h", read_byte);
        mismatch_count++;
      end else begin
        want = expected_bus_results.pop_front();
        if (read_byte !== want.rd_byte) begin
          $error("read_byte: expected %0h, actual %0h", want.rd_byte, read_byte);
          mismatch_count++;
        end
        if (save_dirty !== want.dirty) begin
          $error("save_dirty: expected %0b, actual %0b", want.dirty, save_dirty);
          mismatch_count++;
        end
        if (control_hit !== want.reg_hit) begin
          $error("control_hit: expected %0b, actual %0b", want.reg_hit, control_hit);
          mismatch_count++;
        end
        if (sram_hit !== want.sram_win) begin
          $error("sram_hit: expected %0b, actual %0b", want.sram_win, sram_hit);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= accept_stall_pct);
  end

  task automatic send_item(input logic [2:0] op, input logic [15:0] a,
                           input logic [7:0] v, input logic [ROM_AW-1:0] p);
    int unsigned gap;
    in_valid <= 1'b1;
    mode <= op;
    bus_address <= a;
    write_byte <= v;
    rom_position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bus_results = {expected_bus_results, mapper_step(op, a, v, p)};
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(18, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A ROM byte is loaded first whenever the read would land on one never written.
  task automatic read_bus(input logic [15:0] a);
    int unsigned off;
    if (rom_target(a, off) && !rom_image.exists(off)) begin
      send_item(MODE_LOAD, 16'($urandom), 8'($urandom), ROM_AW'(off));
    end
    send_item(MODE_READ, a, 8'($urandom), ROM_AW'($urandom));
  endtask

  task automatic write_bus(input logic [15:0] a, input logic [7:0] v);
    send_item(MODE_WRITE, a, v, ROM_AW'($urandom));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_cartridge(input logic [LEN_W-1:0] len);
    wait_results_drained();
    cfg_valid <= 1'b1;
    rom_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cartridge_inserted(len);
  endtask

  task automatic run_mixed_traffic(input int unsigned n);
    int unsigned pick;
    int unsigned soff;
    int unsigned span;
    logic [15:0] a;
    logic [7:0]  v;
    repeat (n) begin
      pick = $urandom_range(99);
      v = 8'($urandom);
      if (pick < 35) begin
        span = (cart_len == 0 || cart_len > PAGE_BYTES) ? PAGE_BYTES : cart_len;
        case ($urandom_range(5))
          0: a = 16'($urandom_range(16'h03FF));
          1: a = 16'($urandom_range(16'h7FFF, 16'h0400));
          2: a = 16'($urandom_range(16'hBFFF, 16'h8000));
          3: a = 16'($urandom_range(16'hFFFF, 16'hC000));
          4: a = 16'($urandom_range(2) * PAGE_BYTES + $urandom_range(span - 1));
          default: a = 16'($urandom);
        endcase
        read_bus(a);
      end else if (pick < 55) begin
        a = 16'($urandom_range(16'hBFFF, 16'h8000));
        soff = sram_offset(a);
        if ($urandom_range(1) == 0 && soff < SRAM_BYTES) begin
          v = sram_image[soff];
        end
        write_bus(a, v);
      end else if (pick < 68) begin
        a = $urandom_range(1) ? ADDR_CONTROL : 16'(ADDR_BANK_BASE + $urandom_range(2));
        if (a == ADDR_CONTROL && $urandom_range(9) < 7) begin
          v[CTRL_SRAM_ON] = 1'b1;
        end
        write_bus(a, v);
      end else if (pick < 74) begin
        write_bus(16'($urandom), v);
      end else if (pick < 84) begin
        send_item(MODE_LOAD, 16'($urandom), v, ROM_AW'($urandom));
      end else if (pick < 90) begin
        send_item(MODE_CLEAN, 16'($urandom), v, ROM_AW'($urandom));
      end else if (pick < 95) begin
        send_item(MODE_RESTART, 16'($urandom), v, ROM_AW'($urandom));
      end else begin
        send_item(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), 16'($urandom), v,
                  ROM_AW'($urandom));
      end
    end
  endtask

  task automatic test_no_cartridge();
    load_cartridge('0);
    set_traffic(9, 9);
    read_bus(16'h0000);
    read_bus(16'hBFFF);
    read_bus(ADDR_CONTROL);
    write_bus(ADDR_CONTROL, 8'h08);
    write_bus(ADDR_SRAM_LO, 8'hFF);
    read_bus(ADDR_SRAM_LO);
    send_item(MODE_LOAD, 16'hFFFF, 8'h00, '1);
    send_item(MODE_LOAD, 16'h0000, 8'hFF, '0);
    send_item(MODE_SPARE_HI, 16'hFFFF, 8'hFF, '1);
    run_mixed_traffic(100);
  endtask

  task automatic test_short_rom();
    load_cartridge(20'd1000);
    set_traffic(0, 58);
    read_bus(16'h03FF);
    read_bus(16'h47D0);
    run_mixed_traffic(250);
  endtask

  task automatic test_oversize_length();
    load_cartridge('1);
    set_traffic(0, 0);
    write_bus(ADDR_BANK_BASE, 8'hFF);
    write_bus(16'(ADDR_BANK_BASE + 1), 8'h21);
    write_bus(16'hFFFF, 8'h00);
    write_bus(ADDR_CONTROL, 8'h03);
    read_bus(16'h0400);
    read_bus(16'h7FFF);
    read_bus(16'hBFFF);
    write_bus(ADDR_CONTROL, 8'h0C);
    write_bus(16'hBFFF, 8'h00);
    write_bus(ADDR_SRAM_LO, 8'hA5);
    read_bus(ADDR_SRAM_LO);
    send_item(MODE_CLEAN, 16'h0000, 8'h00, '0);
    write_bus(ADDR_SRAM_LO, 8'hA5);
    send_item(MODE_RESTART, 16'h0000, 8'h00, '0);
    read_bus(16'hFFFE);
    run_mixed_traffic(150);
    wait_results_drained();
    run_mixed_traffic(150);
  endtask

  task automatic test_page_boundaries();
    load_cartridge(20'(PAGE_BYTES));
    set_traffic(58, 0);
    run_mixed_traffic(200);
    load_cartridge(20'(PAGE_BYTES + 1));
    set_traffic(9, 9);
    run_mixed_traffic(200);
  endtask

  task automatic test_random_length();
    load_cartridge(20'($urandom_range(20'hFFFFE, 2)));
    set_traffic(0, 58);
    run_mixed_traffic(250);
  endtask

  task automatic test_single_byte_rom();
    load_cartridge(20'd1);
    set_traffic(58, 0);
    run_mixed_traffic(150);
  endtask

  task automatic test_exact_max_rom();
    load_cartridge(20'(ROM_BYTES));
    set_traffic(0, 0);
    run_mixed_traffic(100);
  endtask

  initial begin
    cartridge_inserted('0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_no_cartridge();
    test_short_rom();
    test_oversize_length();
    test_page_boundaries();
    test_random_length();
    test_single_byte_rom();
    test_exact_max_rom();
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
